[hw/rtl/rec_pkg.sv]
// Shared types and constants for the reciprocal edge counter.
`default_nettype none
package rec_pkg;
	localparam int unsigned VERTEX_W = 10;
	localparam int unsigned COUNT_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Controller commands to the datapath
	typedef struct packed {
		logic capture;   // latch input beat
		logic rd_dst;    // read row dst
		logic rd_src;    // read row src
		logic resolve;   // decide and write back
		logic emit;      // copy of resolve; the datapath leaves it unused
	} rec_cmd_t;

	// Datapath status back to the controller
	typedef struct packed {
		logic clearing;  // clearing pass still running
	} rec_sts_t;
endpackage
`default_nettype wire

[hw/rtl/rec_datapath.sv]
// Datapath: pending table, slot compare, pair counter and result registers.
`default_nettype none
module rec_datapath #(
	parameter int unsigned VERTICES = 1024,
	parameter int unsigned SLOTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rec_pkg::rec_cmd_t             cmd,
	output rec_pkg::rec_sts_t                  sts,
	input  wire logic [rec_pkg::VERTEX_W-1:0]  src,
	input  wire logic [rec_pkg::VERTEX_W-1:0]  dst,
	input  wire logic                          last_edge,
	output logic                               strobe,
	output logic                               matched,
	output logic                               dropped,
	output logic [rec_pkg::COUNT_W-1:0]        pair_count,
	output logic                               done_res
);
	import rec_pkg::*;

	localparam int unsigned ROW_W = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned ROW_BITS = SLOTS * (VERTEX_W + 1);

	typedef logic [SLOTS-1:0][VERTEX_W:0] row_t;

	// One wide row per vertex: valid bit over destination per slot
	row_t mem [VERTICES];

	logic [VERTEX_W-1:0] src_q, dst_q;
	logic                last_q, range_ok_q;
	row_t                rd_data_q, dst_row_q;
	logic [ROW_W-1:0]    clr_addr_q;
	logic                clr_busy_q;
	logic [COUNT_W-1:0]  total_q;

	logic [ROW_W-1:0]    rd_addr;
	logic                wr_en;
	logic [ROW_W-1:0]    wr_addr;
	row_t                wr_data;
	logic                hit, free_found;
	logic [SLOT_W-1:0]   hit_idx, free_idx;
	row_t                take_row, put_row;

	assign sts.clearing = clr_busy_q;

	// Choose read row
	assign rd_addr = cmd.rd_dst ? dst_q[ROW_W-1:0] : src_q[ROW_W-1:0];

	// Find lowest matching slot in row dst, lowest free slot in row src
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		free_found = 1'b0;
		free_idx = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (dst_row_q[k][VERTEX_W] && dst_row_q[k][VERTEX_W-1:0] == src_q) begin
				hit = 1'b1;
				hit_idx = SLOT_W'(k);
			end
			if (!rd_data_q[k][VERTEX_W]) begin
				free_found = 1'b1;
				free_idx = SLOT_W'(k);
			end
		end
		take_row = dst_row_q;
		take_row[hit_idx][VERTEX_W] = 1'b0;
		put_row = rd_data_q;
		put_row[free_idx] = {1'b1, dst_q};
	end

	// Write port: clearing pass or write back
	always_comb begin
		wr_en = 1'b0;
		wr_addr = clr_addr_q;
		wr_data = '0;
		priority if (clr_busy_q) begin
			wr_en = 1'b1;
		end else if (cmd.resolve && range_ok_q) begin
			if (hit) begin
				wr_en = 1'b1;
				wr_addr = dst_q[ROW_W-1:0];
				wr_data = take_row;
			end else if (free_found) begin
				wr_en = 1'b1;
				wr_addr = src_q[ROW_W-1:0];
				wr_data = put_row;
			end
		end
	end

	// Memory port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Hold captured beat and row dst
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			src_q <= src;
			dst_q <= dst;
			last_q <= last_edge;
			range_ok_q <= (32'(src) < VERTICES) && (32'(dst) < VERTICES);
		end
		if (cmd.rd_src) begin
			dst_row_q <= rd_data_q;
		end
	end

	// Clearing pass, count and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			total_q <= '0;
			strobe <= 1'b0;
			matched <= 1'b0;
			dropped <= 1'b0;
			pair_count <= '0;
			done_res <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (32'(clr_addr_q) == VERTICES - 1) begin
					clr_busy_q <= 1'b0;
				end
			end
			strobe <= 1'b0;
			if (cmd.resolve) begin
				strobe <= 1'b1;
				matched <= range_ok_q && hit;
				dropped <= !range_ok_q || (!hit && !free_found);
				done_res <= last_q;
				if (range_ok_q && hit && total_q != COUNT_MAX) begin
					total_q <= total_q + 1'b1;
					pair_count <= total_q + 1'b1;
				end else begin
					pair_count <= total_q;
				end
			end
		end
	end

	logic unused;
	assign unused = cmd.emit ^ (ROW_BITS == 0);
endmodule
`default_nettype wire

[hw/rtl/rec_ctrl.sv]
// Controller: sequences capture, two row reads and write back per edge.
`default_nettype none
module rec_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output rec_pkg::rec_cmd_t      cmd,
	input  wire rec_pkg::rec_sts_t sts
);
	import rec_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RD_DST, ST_RD_SRC, ST_RESOLVE} state_t;
	state_t state_q;

	assign busy = (state_q != ST_IDLE) || sts.clearing;

	always_comb begin
		cmd = '0;
		cmd.capture = start && !busy;
		cmd.rd_dst = (state_q == ST_RD_DST);
		cmd.rd_src = (state_q == ST_RD_SRC);
		cmd.resolve = (state_q == ST_RESOLVE);
		cmd.emit = cmd.resolve;
	end

	// Advance through the edge sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start && !busy) state_q <= ST_RD_DST;
				ST_RD_DST: state_q <= ST_RD_SRC;
				ST_RD_SRC: state_q <= ST_RESOLVE;
				ST_RESOLVE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[hw/rtl/reciprocal_edge_counter_unit.sv]
// Top level of the reciprocal edge counter.
//
// channel | handshake           | payload
// edge in | start & !busy       | src, dst, last_edge
// result  | strobe (one cycle)  | matched, dropped, pair_count, done_res
//
// Each edge runs through capture, read row dst, read row src and write back, in order.
// The row memory has one read port and one write port; each edge makes two reads and one write.
// After reset a clearing pass writes every row to zero; busy stays high meanwhile.
// The result receiver cannot stall; each result shows for one cycle.
`default_nettype none
module reciprocal_edge_counter_unit #(
	parameter int unsigned VERTICES = 1024,
	parameter int unsigned SLOTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rec_pkg::VERTEX_W-1:0]  src,
	input  wire logic [rec_pkg::VERTEX_W-1:0]  dst,
	input  wire logic                          last_edge,
	output logic                               strobe,
	output logic                               matched,
	output logic                               dropped,
	output logic [rec_pkg::COUNT_W-1:0]        pair_count,
	output logic                               done_res
);
	import rec_pkg::*;

	rec_cmd_t cmd;
	rec_sts_t sts;

	rec_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
	);

	rec_datapath #(.VERTICES(VERTICES), .SLOTS(SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.src(src), .dst(dst), .last_edge(last_edge),
		.strobe(strobe), .matched(matched), .dropped(dropped),
		.pair_count(pair_count), .done_res(done_res)
	);
endmodule
`default_nettype wire

[hw/rtl/rec_checker.sv]
// Port checker for the reciprocal edge counter, bound to the top level.
`default_nettype none
module rec_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        strobe,
	input wire logic        matched,
	input wire logic        dropped,
	input wire logic [31:0] pair_count
);
	// A result never claims both a match and a drop
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(matched && dropped)) else $error("matched and dropped");

	// An accepted beat yields a result strobe once it has passed the read and resolve states
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 strobe) else $error("missing result");

	// A result strobe only follows a busy controller
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("strobe while idle");

	// Count never decreases between back-to-back results
	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe, 4) |-> pair_count >= $past(pair_count, 4))
		else $error("count decreased");
endmodule

bind reciprocal_edge_counter_unit rec_checker u_rec_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.matched(matched), .dropped(dropped), .pair_count(pair_count)
);
`default_nettype wire

[tb/reciprocal_edge_counter_unit_tb.sv]
// Testbench for the reciprocal edge counter: directed and random edges against a table model.
`timescale 1ns / 100ps
module reciprocal_edge_counter_unit_tb;
	import rec_pkg::*;

	localparam int unsigned NUM_VERT = 1024;
	localparam int unsigned NUM_SLOTS = 16;
	localparam int unsigned RANDOM_EDGES = 1820;

	typedef struct {
		bit               matched;
		bit               dropped;
		bit [COUNT_W-1:0] pair_count;
		bit               done_res;
	} pair_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [VERTEX_W-1:0] src;
	logic [VERTEX_W-1:0] dst;
	logic                last_edge;
	logic                strobe;
	logic                matched;
	logic                dropped;
	logic [COUNT_W-1:0]  pair_count;
	logic                done_res;

	// pending edge table kept by the model
	bit [VERTEX_W-1:0] row_dest [NUM_VERT][NUM_SLOTS];
	bit                row_valid [NUM_VERT][NUM_SLOTS];
	bit [COUNT_W-1:0]  pairs_seen;

	pair_result_t expected_results [$];
	int unsigned  error_count;
	int unsigned  edges_sent;
	int unsigned  match_count;
	int unsigned  drop_count;
	bit           gaps_enabled;

	reciprocal_edge_counter_unit #(
		.VERTICES(NUM_VERT),
		.SLOTS(NUM_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.src(src),
		.dst(dst),
		.last_edge(last_edge),
		.strobe(strobe),
		.matched(matched),
		.dropped(dropped),
		.pair_count(pair_count),
		.done_res(done_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Resolve one edge against the table: match row dst first, else store in row src
	function automatic pair_result_t count_pair(bit [VERTEX_W-1:0] s, bit [VERTEX_W-1:0] d,
			bit last);
		pair_result_t r;
		bit           found;
		found = 1'b0;
		r.matched = 1'b0;
		r.dropped = 1'b0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (!found && row_valid[d][k] && row_dest[d][k] == s) begin
				row_valid[d][k] = 1'b0;
				found = 1'b1;
			end
		end
		if (found) begin
			r.matched = 1'b1;
			if (pairs_seen != COUNT_MAX)
				pairs_seen++;
		end else begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				if (!found && !row_valid[s][k]) begin
					row_dest[s][k] = d;
					row_valid[s][k] = 1'b1;
					found = 1'b1;
				end
			end
			r.dropped = !found;
		end
		r.pair_count = pairs_seen;
		r.done_res = last;
		return r;
	endfunction

	// Send one edge beat; hold start until the block takes it
	task automatic send_edge(bit [VERTEX_W-1:0] s, bit [VERTEX_W-1:0] d, bit last);
		bit was_busy;
		@(negedge clk);
		start <= 1'b1;
		src <= s;
		dst <= d;
		last_edge <= last;
		forever begin
			was_busy = busy;
			@(posedge clk);
			if (!was_busy)
				break;
			@(negedge clk);
		end
		expected_results.push_back(count_pair(s, d, last));
		edges_sent++;
		// idle now and then
		if (gaps_enabled && $urandom_range(99) < 11) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(5)) @(negedge clk);
		end
	endtask

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		pair_result_t e;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				$error("result beat with no edge pending");
				error_count++;
			end else begin
				e = expected_results.pop_front();
				if (matched !== e.matched) begin
					$error("matched: expected %0d, got %0d", e.matched, matched);
					error_count++;
				end
				if (dropped !== e.dropped) begin
					$error("dropped: expected %0d, got %0d", e.dropped, dropped);
					error_count++;
				end
				if (pair_count !== e.pair_count) begin
					$error("pair_count: expected %0d, got %0d", e.pair_count, pair_count);
					error_count++;
				end
				if (done_res !== e.done_res) begin
					$error("done_res: expected %0d, got %0d", e.done_res, done_res);
					error_count++;
				end
				match_count += e.matched;
				drop_count += e.dropped;
			end
		end
	end

	task automatic test_self_loops();
		send_edge(10'd0, 10'd0, 1'b0);
		send_edge(10'd0, 10'd0, 1'b0);
		send_edge(10'd1023, 10'd1023, 1'b0);
		send_edge(10'd1023, 10'd1023, 1'b0);
	endtask

	task automatic test_reciprocal_pairs();
		send_edge(10'd1023, 10'd0, 1'b0);
		send_edge(10'd0, 10'd1023, 1'b0);
		send_edge(10'h155, 10'h2AA, 1'b0);
		send_edge(10'h2AA, 10'h155, 1'b0);
	endtask

	task automatic test_repeated_edges();
		send_edge(10'd7, 10'd9, 1'b0);
		send_edge(10'd7, 10'd9, 1'b0);
		send_edge(10'd9, 10'd7, 1'b0);
		send_edge(10'd9, 10'd7, 1'b0);
		send_edge(10'd9, 10'd7, 1'b0);
	endtask

	// Fill one row, then overflow it
	task automatic test_row_overflow();
		for (int k = 0; k <= NUM_SLOTS; k++)
			send_edge(10'd5, 10'(100 + k), 1'b0);
	endtask

	// End marker keeps the table; the next edge continues the run
	task automatic test_end_marker();
		send_edge(10'd9, 10'd7, 1'b1);
		send_edge(10'd116, 10'd5, 1'b0);
	endtask

	// Mostly edges within small vertex windows so pairs and full rows occur
	task automatic test_random_traffic();
		bit [VERTEX_W-1:0] base;
		bit [VERTEX_W-1:0] s;
		bit [VERTEX_W-1:0] d;
		base = VERTEX_W'($urandom_range(NUM_VERT - 1));
		for (int n = 0; n < RANDOM_EDGES; n++) begin
			gaps_enabled = !(n >= 600 && n < 1000);
			if ($urandom_range(99) < 3)
				base = VERTEX_W'($urandom_range(NUM_VERT - 1));
			if ($urandom_range(99) < 80) begin
				s = base + VERTEX_W'($urandom_range(7));
				d = base + VERTEX_W'($urandom_range(7));
			end else begin
				s = VERTEX_W'($urandom_range(NUM_VERT - 1));
				d = VERTEX_W'($urandom_range(NUM_VERT - 1));
			end
			send_edge(s, d, $urandom_range(7) == 0);
		end
		gaps_enabled = 1'b1;
	endtask

	initial begin
		int unsigned wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		src = '0;
		dst = '0;
		last_edge = 1'b0;
		pairs_seen = '0;
		error_count = 0;
		edges_sent = 0;
		match_count = 0;
		drop_count = 0;
		gaps_enabled = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_self_loops();
		test_reciprocal_pairs();
		test_repeated_edges();
		test_row_overflow();
		test_end_marker();
		test_random_traffic();

		@(negedge clk);
		start <= 1'b0;
		wait_cycles = 0;
		while (expected_results.size() != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			error_count++;
		end
		repeat (10) @(posedge clk);
		$display("Sent %0d edges: %0d completed pairs, %0d dropped on full rows.",
			edges_sent, match_count, drop_count);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
